// ----- sv/contour_area_center_dedup_top_macros.svh -----
// Assertion macros shared by the contour area and centre filter.
// Included by the modules that check their own logic; no other dependencies.
`ifndef CONTOUR_AREA_CENTER_DEDUP_TOP_MACROS_SVH
`define CONTOUR_AREA_CENTER_DEDUP_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CACD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cacd: assertion failed");
`define CACD_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("cacd: forbidden condition seen");
`else
`define CACD_ASSERT(name, prop)
`define CACD_NEVER(name, cond)
`endif

`endif

// ----- sv/cacd_pkg.sv -----
// Types and constants of the contour area and centre filter.
// Used by every module of the block but cacd_ram; depends on nothing.
package cacd_pkg;

  localparam int COORD_BITS    = 12;
  localparam int PROD_BITS     = 2 * COORD_BITS;
  localparam int SUM_BITS      = 48;
  localparam int AREA_BITS     = 25;
  localparam int MIN_AREA_BITS = 24;
  localparam int MIN_DIST_BITS = 12;
  localparam int VERDICT_BITS  = 2;
  localparam int ENTRY_BITS    = 2 * COORD_BITS;
  localparam int ADDR_BITS     = 3;
  localparam int DATA_BITS     = 32;

  localparam logic [MIN_AREA_BITS-1:0] MIN_AREA_RESET     = 24'd2000;
  localparam logic [MIN_DIST_BITS-1:0] MIN_DISTANCE_RESET = 12'd25;

  // Register index, taken from paddr bit 2.
  localparam logic REG_MIN_AREA     = 1'b0;
  localparam logic REG_MIN_DISTANCE = 1'b1;

  localparam logic [VERDICT_BITS-1:0] VERDICT_STORED    = 2'd0;
  localparam logic [VERDICT_BITS-1:0] VERDICT_TOO_SMALL = 2'd1;
  localparam logic [VERDICT_BITS-1:0] VERDICT_DUPLICATE = 2'd2;
  localparam logic [VERDICT_BITS-1:0] VERDICT_FULL      = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;
  } point_t;

  typedef struct packed {
    logic [AREA_BITS-1:0]    area_twice;
    logic [COORD_BITS-1:0]   center_x;
    logic [COORD_BITS-1:0]   center_y;
    logic [VERDICT_BITS-1:0] verdict;
  } result_t;

  // A finished contour on its way from the front end to the table search.
  typedef struct packed {
    logic [AREA_BITS-1:0]  area_twice;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic                  too_small;
  } cand_t;

endpackage

// ----- sv/cacd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Holds the table of stored centres; depends on nothing.
module cacd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- sv/cacd_queue.sv -----
// Two-entry queue between the point front end and the table search.
// Depends on cacd_pkg and the assertion macros.
`include "contour_area_center_dedup_top_macros.svh"

module cacd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cacd_pkg::cand_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output cacd_pkg::cand_t data_o
);
  import cacd_pkg::*;

  cand_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `CACD_NEVER(push_when_full, push_i && full_o)
  `CACD_NEVER(pop_when_empty, pop_i && !valid_o)

endmodule

// ----- sv/cacd_front.sv -----
// Point front end: shoelace sum over one shared multiplier, bounding box,
// and area classification of each finished contour. Depends on cacd_pkg.
`include "contour_area_center_dedup_top_macros.svh"

module cacd_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  cacd_pkg::point_t                     in_data_i,
  input  logic [cacd_pkg::MIN_AREA_BITS-1:0]   min_area_i,
  output logic                                 q_push_o,
  output cacd_pkg::cand_t                      q_data_o,
  input  logic                                 q_full_i
);
  import cacd_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_M1   = 3'd1;
  localparam logic [2:0] F_M2   = 3'd2;
  localparam logic [2:0] F_C1   = 3'd3;
  localparam logic [2:0] F_C2   = 3'd4;
  localparam logic [2:0] F_FIN  = 3'd5;
  localparam logic [2:0] F_MAG  = 3'd6;
  localparam logic [2:0] F_PUSH = 3'd7;

  logic [2:0]            state_q, state_d;
  logic                  in_contour_q;
  logic                  prod_vld_q;
  logic                  acc;

  logic [COORD_BITS-1:0] cur_x_q, cur_y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic [COORD_BITS-1:0] box_min_x_q, box_min_y_q, box_max_x_q, box_max_y_q;
  logic [COORD_BITS-1:0] cx_q, cy_q;
  logic                  last_q;
  logic [PROD_BITS-1:0]  prod_q, prod_d;
  logic                  prod_neg_q;
  logic [SUM_BITS-1:0]   cross_q, cross_acc, term;
  logic [SUM_BITS-1:0]   mag_q;
  logic [COORD_BITS-1:0] mul_a, mul_b;

  // A new point may enter while the second product of the previous one runs.
  assign in_stall_o = !((state_q == F_IDLE) || ((state_q == F_M2) && !last_q));
  assign acc        = in_valid_i && !in_stall_o;

  // Each point adds prev.x*cur.y and subtracts cur.x*prev.y; the closing pair
  // uses the last point in place of prev and the first point in place of cur.
  always_comb begin
    case (state_q)
      F_M1: begin
        mul_a = prev_x_q;
        mul_b = cur_y_q;
      end
      F_M2: begin
        mul_a = cur_x_q;
        mul_b = prev_y_q;
      end
      F_C2: begin
        mul_a = first_x_q;
        mul_b = cur_y_q;
      end
      default: begin
        mul_a = cur_x_q;
        mul_b = first_y_q;
      end
    endcase
  end

  assign prod_d    = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
  assign term      = SUM_BITS'(prod_q);
  assign cross_acc = prod_neg_q ? (cross_q - term) : (cross_q + term);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (acc) begin
          if (!in_contour_q) begin
            state_d = in_data_i.last_point ? F_C1 : F_IDLE;
          end else begin
            state_d = F_M1;
          end
        end
      end
      F_M1: state_d = F_M2;
      F_M2: begin
        if (last_q) begin
          state_d = F_C1;
        end else begin
          state_d = acc ? F_M1 : F_IDLE;
        end
      end
      F_C1:  state_d = F_C2;
      F_C2:  state_d = F_FIN;
      F_FIN: state_d = F_MAG;
      F_MAG: state_d = F_PUSH;
      F_PUSH: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      in_contour_q <= 1'b0;
      prod_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      prod_vld_q <= (state_q == F_M1) || (state_q == F_M2) ||
                    (state_q == F_C1) || (state_q == F_C2);
      if (q_push_o) begin
        in_contour_q <= 1'b0;
      end else if (acc) begin
        in_contour_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    prod_neg_q <= (state_q == F_M2) || (state_q == F_C2);
    if (acc) begin
      cur_x_q <= in_data_i.point_x;
      cur_y_q <= in_data_i.point_y;
      last_q  <= in_data_i.last_point;
      if (!in_contour_q) begin
        first_x_q   <= in_data_i.point_x;
        first_y_q   <= in_data_i.point_y;
        prev_x_q    <= in_data_i.point_x;
        prev_y_q    <= in_data_i.point_y;
        box_min_x_q <= in_data_i.point_x;
        box_max_x_q <= in_data_i.point_x;
        box_min_y_q <= in_data_i.point_y;
        box_max_y_q <= in_data_i.point_y;
      end else begin
        if (in_data_i.point_x < box_min_x_q) box_min_x_q <= in_data_i.point_x;
        if (in_data_i.point_y < box_min_y_q) box_min_y_q <= in_data_i.point_y;
        if (in_data_i.point_x > box_max_x_q) box_max_x_q <= in_data_i.point_x;
        if (in_data_i.point_y > box_max_y_q) box_max_y_q <= in_data_i.point_y;
      end
    end
    if (state_q == F_M2) begin
      prev_x_q <= cur_x_q;
      prev_y_q <= cur_y_q;
    end
    if (acc && !in_contour_q) begin
      cross_q <= '0;
    end else if (prod_vld_q) begin
      cross_q <= cross_acc;
    end
    if (state_q == F_MAG) begin
      // Negating the most negative sum leaves it as its own magnitude.
      mag_q <= cross_q[SUM_BITS-1] ? (SUM_BITS'(0) - cross_q) : cross_q;
      cx_q  <= box_min_x_q + ((box_max_x_q - box_min_x_q) >> 1);
      cy_q  <= box_min_y_q + ((box_max_y_q - box_min_y_q) >> 1);
    end
  end

  assign q_push_o            = (state_q == F_PUSH) && !q_full_i;
  assign q_data_o.area_twice = (|mag_q[SUM_BITS-1:AREA_BITS]) ? '1 : mag_q[AREA_BITS-1:0];
  assign q_data_o.center_x   = cx_q;
  assign q_data_o.center_y   = cy_q;
  assign q_data_o.too_small  = mag_q < SUM_BITS'({min_area_i, 1'b0});

  `CACD_ASSERT(push_on_last_point, q_push_o |-> last_q && !prod_vld_q)
  `CACD_ASSERT(push_ends_contour, q_push_o |=> !in_contour_q && state_q == F_IDLE)

endmodule

// ----- sv/cacd_back.sv -----
// Table search: compares the centre of each contour that passed the area test
// with every stored centre by squared distance, stores or flags it, and holds
// the result register. Depends on cacd_pkg, cacd_ram and the assertion macros.
`include "contour_area_center_dedup_top_macros.svh"

module cacd_back #(
  parameter int CENTER_SLOTS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  input  cacd_pkg::cand_t                    q_data_i,
  output logic                               q_pop_o,
  input  logic [cacd_pkg::MIN_DIST_BITS-1:0] min_distance_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output cacd_pkg::result_t                  out_data_o
);
  import cacd_pkg::*;

  localparam int AW = (CENTER_SLOTS > 1) ? $clog2(CENTER_SLOTS) : 1;
  localparam int CW = $clog2(CENTER_SLOTS + 1);

  localparam logic [1:0] B_IDLE   = 2'd0;
  localparam logic [1:0] B_SCAN   = 2'd1;
  localparam logic [1:0] B_DRAIN  = 2'd2;
  localparam logic [1:0] B_RESULT = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [CW-1:0]           cnt_q, idx_q;
  logic                    v1_q, v2_q, v3_q;
  logic                    hit_q;
  logic                    out_valid_q;
  cand_t                   cand_q;
  result_t                 out_q;
  logic [PROD_BITS-1:0]    md2_q;
  logic [COORD_BITS-1:0]   dx_q, dy_q;
  logic [PROD_BITS-1:0]    sqx_q, sqy_q;
  logic [ENTRY_BITS-1:0]   rdata;
  logic [COORD_BITS-1:0]   ent_x, ent_y;
  logic                    rd_en, ram_we, out_free, near;
  logic [VERDICT_BITS-1:0] verdict;

  assign rd_en    = (state_q == B_SCAN) && (idx_q < cnt_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == B_IDLE) && q_valid_i;
  assign ent_x    = rdata[ENTRY_BITS-1:COORD_BITS];
  assign ent_y    = rdata[COORD_BITS-1:0];
  assign near     = (AREA_BITS'(sqx_q) + AREA_BITS'(sqy_q)) < AREA_BITS'(md2_q);

  always_comb begin
    if (cand_q.too_small) begin
      verdict = VERDICT_TOO_SMALL;
    end else if (hit_q) begin
      verdict = VERDICT_DUPLICATE;
    end else if (cnt_q < CW'(CENTER_SLOTS)) begin
      verdict = VERDICT_STORED;
    end else begin
      verdict = VERDICT_FULL;
    end
  end

  assign ram_we = (state_q == B_RESULT) && out_free && (verdict == VERDICT_STORED);

  cacd_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (CENTER_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({cand_q.center_x, cand_q.center_y}),
    .re_i    (rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          state_d = q_data_i.too_small ? B_RESULT : B_SCAN;
        end
      end
      B_SCAN: begin
        if (!rd_en) begin
          state_d = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (!(v1_q || v2_q || v3_q)) begin
          state_d = B_RESULT;
        end
      end
      B_RESULT: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= rd_en;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      if (ram_we) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if ((state_q == B_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    md2_q <= PROD_BITS'(min_distance_i) * PROD_BITS'(min_distance_i);
    dx_q  <= (ent_x > cand_q.center_x) ? (ent_x - cand_q.center_x)
                                       : (cand_q.center_x - ent_x);
    dy_q  <= (ent_y > cand_q.center_y) ? (ent_y - cand_q.center_y)
                                       : (cand_q.center_y - ent_y);
    sqx_q <= PROD_BITS'(dx_q) * PROD_BITS'(dx_q);
    sqy_q <= PROD_BITS'(dy_q) * PROD_BITS'(dy_q);
    if (q_pop_o) begin
      cand_q <= q_data_i;
      idx_q  <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (rd_en) begin
        idx_q <= idx_q + CW'(1);
      end
      if (v3_q && near) begin
        hit_q <= 1'b1;
      end
    end
    if ((state_q == B_RESULT) && out_free) begin
      out_q.area_twice <= cand_q.area_twice;
      out_q.center_x   <= cand_q.center_x;
      out_q.center_y   <= cand_q.center_y;
      out_q.verdict    <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CACD_ASSERT(store_bumps_count, ram_we |=> cnt_q == $past(cnt_q) + CW'(1))
  `CACD_NEVER(count_over_slots, cnt_q > CW'(CENTER_SLOTS))
  `CACD_NEVER(read_while_storing, rd_en && ram_we)

endmodule

// ----- sv/contour_area_center_dedup_top.sv -----
// Contour area and centre filter, top level: configuration registers, point
// front end, queue and table search. Depends on cacd_pkg and all cacd modules.
//
// Points of a contour enter one per transaction. The first point of a contour
// forms no product; each later point but the last uses the front end's single
// 12x12 multiplier to form the two shoelace cross products in turn, and the
// next point may enter while the second runs. For the last point the front end
// forms its own products (none if it is also the first), the closing pair back
// to the first point, the accumulate, the magnitude and the hand-off to the
// queue, which waits while it is full. Each contour that passes the area test
// is then searched against the centre table at one entry per cycle through the
// table RAM read port; a two-entry queue lets the next contour's points stream
// in meanwhile. One result transaction leaves per contour. The table is never
// cleared and needs no clearing pass after reset. The user must write
// registers min_area (offset 0x0) and min_distance (offset 0x4) over the APB
// port only while the block is idle; the block does not enforce this.
module contour_area_center_dedup_top #(
  parameter int CENTER_SLOTS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  cacd_pkg::point_t                      in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output cacd_pkg::result_t                     out_data_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [cacd_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [cacd_pkg::DATA_BITS-1:0]        pwdata,
  output logic [cacd_pkg::DATA_BITS-1:0]        prdata,
  output logic                                  pready
);
  import cacd_pkg::*;

  logic [MIN_AREA_BITS-1:0] min_area_q;
  logic [MIN_DIST_BITS-1:0] min_dist_q;
  logic                     cfg_wr;
  logic                     q_push, q_full, q_valid, q_pop;
  cand_t                    q_in, q_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_area_q <= MIN_AREA_RESET;
      min_dist_q <= MIN_DISTANCE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MIN_AREA) begin
        min_area_q <= pwdata[MIN_AREA_BITS-1:0];
      end else begin
        min_dist_q <= pwdata[MIN_DIST_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MIN_DISTANCE) ? DATA_BITS'(min_dist_q)
                                                 : DATA_BITS'(min_area_q);

  cacd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .min_area_i (min_area_q),
    .q_push_o   (q_push),
    .q_data_o   (q_in),
    .q_full_i   (q_full)
  );

  cacd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  cacd_back #(
    .CENTER_SLOTS (CENTER_SLOTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_out),
    .q_pop_o        (q_pop),
    .min_distance_i (min_dist_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

// ----- test/tb_contour_area_center_dedup_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the contour area and centre filter: sends contours
// point by point, predicts every result in a scoreboard class and checks it.
// Depends on cacd_pkg and contour_area_center_dedup_top.

module tb_contour_area_center_dedup_top;
  import cacd_pkg::*;

  localparam int TABLE_SLOTS = 64;
  localparam logic [AREA_BITS-1:0] AREA_SAT = '1;
  localparam logic [ADDR_BITS-1:0] ADDR_MIN_AREA = {REG_MIN_AREA, 2'b00};
  localparam logic [ADDR_BITS-1:0] ADDR_MIN_DISTANCE = {REG_MIN_DISTANCE, 2'b00};
  // Front end plus a full table search, with margin.
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES = 300;

  class contour_scoreboard;
    bit [MIN_AREA_BITS-1:0] min_area;
    bit [MIN_DIST_BITS-1:0] min_distance;
    bit [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y;
    bit [COORD_BITS-1:0] lo_x, lo_y, hi_x, hi_y;
    bit [SUM_BITS-1:0] cross_sum;
    bit in_contour;
    bit [COORD_BITS-1:0] table_x[TABLE_SLOTS];
    bit [COORD_BITS-1:0] table_y[TABLE_SLOTS];
    int table_used;
    result_t expected_q[$];
    int errors;
    int matched;
    int verdict_seen[4];

    function new();
      min_area = MIN_AREA_RESET;
      min_distance = MIN_DISTANCE_RESET;
      in_contour = 1'b0;
      cross_sum = '0;
      table_used = 0;
      errors = 0;
      matched = 0;
      foreach (verdict_seen[i]) verdict_seen[i] = 0;
    endfunction

    // Adds the shoelace term a.x*b.y - b.x*a.y, wrapping at the sum width.
    function void add_cross(bit [COORD_BITS-1:0] ax, bit [COORD_BITS-1:0] ay,
                            bit [COORD_BITS-1:0] bx, bit [COORD_BITS-1:0] by);
      bit [SUM_BITS-1:0] wax, way, wbx, wby;
      wax = ax;
      way = ay;
      wbx = bx;
      wby = by;
      cross_sum = cross_sum + wax * wby - wbx * way;
    endfunction

    function void note_point(point_t p);
      bit [SUM_BITS-1:0] mag;
      bit [COORD_BITS-1:0] cx, cy;
      bit dup;
      longint unsigned dx, dy, md2;
      result_t r;
      if (!in_contour) begin
        first_x = p.point_x;
        first_y = p.point_y;
        prev_x = p.point_x;
        prev_y = p.point_y;
        cross_sum = '0;
        lo_x = p.point_x;
        hi_x = p.point_x;
        lo_y = p.point_y;
        hi_y = p.point_y;
        in_contour = 1'b1;
      end else begin
        add_cross(prev_x, prev_y, p.point_x, p.point_y);
        prev_x = p.point_x;
        prev_y = p.point_y;
        if (p.point_x < lo_x) lo_x = p.point_x;
        if (p.point_y < lo_y) lo_y = p.point_y;
        if (p.point_x > hi_x) hi_x = p.point_x;
        if (p.point_y > hi_y) hi_y = p.point_y;
      end
      if (!p.last_point) return;

      add_cross(prev_x, prev_y, first_x, first_y);
      mag = cross_sum[SUM_BITS-1] ? ~cross_sum + SUM_BITS'(1) : cross_sum;
      cx = lo_x + ((hi_x - lo_x) >> 1);
      cy = lo_y + ((hi_y - lo_y) >> 1);
      r.area_twice = (mag > AREA_SAT) ? AREA_SAT : mag[AREA_BITS-1:0];
      r.center_x = cx;
      r.center_y = cy;

      if (mag < {min_area, 1'b0}) begin
        r.verdict = VERDICT_TOO_SMALL;
      end else begin
        dup = 1'b0;
        md2 = longint'(min_distance) * longint'(min_distance);
        for (int i = 0; i < table_used && !dup; i++) begin
          dx = (table_x[i] > cx) ? table_x[i] - cx : cx - table_x[i];
          dy = (table_y[i] > cy) ? table_y[i] - cy : cy - table_y[i];
          if (dx * dx + dy * dy < md2) dup = 1'b1;
        end
        if (dup) begin
          r.verdict = VERDICT_DUPLICATE;
        end else if (table_used < TABLE_SLOTS) begin
          table_x[table_used] = cx;
          table_y[table_used] = cy;
          table_used++;
          r.verdict = VERDICT_STORED;
        end else begin
          r.verdict = VERDICT_FULL;
        end
      end
      expected_q = {expected_q, r};
      in_contour = 1'b0;
    endfunction

    function bit field_ok(string name, longint unsigned want, longint unsigned got);
      if (want == got) return 1'b1;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1'b0;
    endfunction

    function void check_result(result_t got);
      result_t want;
      bit ok;
      if (expected_q.size() == 0) begin
        $display("%0t: result transaction with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      ok = field_ok("area_twice", want.area_twice, got.area_twice);
      ok &= field_ok("center_x", want.center_x, got.center_x);
      ok &= field_ok("center_y", want.center_y, got.center_y);
      ok &= field_ok("verdict", want.verdict, got.verdict);
      if (ok) matched++;
      else errors++;
      verdict_seen[want.verdict]++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  point_t in_data;
  logic out_valid;
  logic out_stall;
  result_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  contour_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  int items_sent;
  int hold_reqs;
  int hold_left;

  contour_area_center_dedup_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  function automatic bit [COORD_BITS-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return v[COORD_BITS-1:0];
  endfunction

  task automatic send_point(bit [COORD_BITS-1:0] x, bit [COORD_BITS-1:0] y, bit last);
    point_t p;
    p.point_x = x;
    p.point_y = y;
    p.last_point = last;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    // Stall is settled by the falling edge; the transaction completes at the next rise.
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sb.note_point(p);
    items_sent++;
  endtask

  // Rectangle, counterclockwise unless reversed, traced the given number of times.
  task automatic send_box(bit [COORD_BITS-1:0] x0, bit [COORD_BITS-1:0] y0,
                          bit [COORD_BITS-1:0] x1, bit [COORD_BITS-1:0] y1,
                          bit reverse, int laps);
    bit [COORD_BITS-1:0] xs[4];
    bit [COORD_BITS-1:0] ys[4];
    int idx;
    xs = '{x0, x1, x1, x0};
    ys = '{y0, y0, y1, y1};
    for (int lap = 0; lap < laps; lap++) begin
      for (int k = 0; k < 4; k++) begin
        idx = reverse ? 3 - k : k;
        send_point(xs[idx], ys[idx], lap == laps - 1 && k == 3);
      end
    end
  endtask

  task automatic send_contour(int max_len, int near_pct, int box_pct);
    int roll, n, span, bx, by, cx, cy, hw, hh, pick;
    roll = $urandom_range(99);
    cx = $urandom_range(4095);
    cy = $urandom_range(4095);
    hw = $urandom_range(600, 1);
    hh = $urandom_range(600, 1);
    if (roll < near_pct && sb.table_used > 0) begin
      // Centre close to one already in the table.
      pick = $urandom_range(sb.table_used - 1);
      cx = int'(sb.table_x[pick]) + int'($urandom_range(80)) - 40;
      cy = int'(sb.table_y[pick]) + int'($urandom_range(80)) - 40;
      send_box(clamp_coord(cx - hw), clamp_coord(cy - hh), clamp_coord(cx + hw),
               clamp_coord(cy + hh), 1'($urandom_range(1)), 1);
    end else if (roll < near_pct + 3) begin
      send_box(clamp_coord(cx - 2000), clamp_coord(cy - 2000), clamp_coord(cx + 2000),
               clamp_coord(cy + 2000), 1'($urandom_range(1)), 2);
    end else if (roll < near_pct + 3 + box_pct) begin
      send_box(clamp_coord(cx - hw), clamp_coord(cy - hh), clamp_coord(cx + hw),
               clamp_coord(cy + hh), 1'($urandom_range(1)), 1);
    end else begin
      n = $urandom_range(max_len, 1);
      case ($urandom_range(2))
        0: span = 31;
        1: span = 511;
        default: span = 4095;
      endcase
      bx = $urandom_range(4095 - span);
      by = $urandom_range(4095 - span);
      for (int k = 0; k < n; k++) begin
        send_point(COORD_BITS'(bx + $urandom_range(span)),
                   COORD_BITS'(by + $urandom_range(span)), k == n - 1);
      end
    end
  endtask

  task automatic apb_write(logic [ADDR_BITS-1:0] addr, logic [DATA_BITS-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== data) begin
      $display("%0t: register at %0h reads back wrong, expected %0h, actual %0h",
               $time, addr, data, prdata);
      sb.errors++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limits(bit [MIN_AREA_BITS-1:0] area, bit [MIN_DIST_BITS-1:0] dist_lim);
    apb_write(ADDR_MIN_AREA, DATA_BITS'(area));
    apb_write(ADDR_MIN_DISTANCE, DATA_BITS'(dist_lim));
    sb.min_area = area;
    sb.min_distance = dist_lim;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int n, bit [MIN_AREA_BITS-1:0] area,
                           bit [MIN_DIST_BITS-1:0] dist_lim,
                           int idle, int stall, int max_len, int near_pct, int box_pct,
                           bit hold);
    int target;
    drain();
    set_limits(area, dist_lim);
    send_idle_pct = idle;
    stall_pct = stall;
    if (hold) hold_reqs++;
    target = items_sent + n;
    while (items_sent < target) send_contour(max_len, near_pct, box_pct);
  endtask

  // Result side: random stalls, plus one long hold-off counted here.
  initial begin
    int hold_taken;
    hold_taken = 0;
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = hold_reqs;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    hold_reqs = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed contours under the reset limits.
    send_point(12'd0, 12'd0, 1'b1);
    send_box(12'd0, 12'd0, 12'd4095, 12'd4095, 1'b0, 1);
    send_box(12'd0, 12'd0, 12'd4095, 12'd4095, 1'b1, 1);
    send_box(12'd0, 12'd0, 12'd4095, 12'd4095, 1'b0, 2);
    send_point(12'd100, 12'd100, 1'b0);
    send_point(12'd110, 12'd100, 1'b0);
    send_point(12'd100, 12'd110, 1'b1);
    send_point(12'd4095, 12'd4095, 1'b1);
    send_point(12'd3000, 12'd100, 1'b0);
    send_point(12'd4000, 12'd100, 1'b0);
    send_point(12'd3500, 12'd900, 1'b1);

    run_phase(90, 24'd500, 12'd60, 0, 0, 8, 30, 30, 1'b0);
    run_phase(60, 24'd16777215, 12'd4095, 52, 0, 6, 10, 30, 1'b0);
    // Tiny contours with no area or distance limit fill the table.
    run_phase(90, 24'd0, 12'd0, 0, 52, 2, 0, 0, 1'b0);
    run_phase(110, 24'd3000, 12'd300, 30, 30, 8, 30, 30, 1'b0);
    run_phase(100, 24'd1, 12'd9, 0, 20, 6, 25, 30, 1'b1);
    drain();

    $display("Sent %0d points over six limit settings; %0d results matched.",
             items_sent, sb.matched);
    $display("Verdicts: %0d stored, %0d too small, %0d duplicate, %0d table full.",
             sb.verdict_seen[VERDICT_STORED], sb.verdict_seen[VERDICT_TOO_SMALL],
             sb.verdict_seen[VERDICT_DUPLICATE], sb.verdict_seen[VERDICT_FULL]);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
